>>> sv/ihsl_pkg.sv
// Shared types, constants and the size-table lookup for the interrupt handler
// signature locator. No dependencies.
package ihsl_pkg;

  localparam int END_SEARCH_LIMIT_DEF = 50;
  localparam int INDEX_WIDTH_DEF = 21;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int NUM_SIZES = 18;
  localparam int PADDR_WIDTH = 4;
  localparam int ESC_WIDTH = 6;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_SCAN = 2'd1;
  localparam logic [1:0] STATUS_TABLE = 2'd2;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_REGION = 2'd1;
  localparam logic [1:0] REG_UNIT = 2'd2;

  localparam logic [31:0] START_SIG [0:4] = '{
    32'he92d4000, 32'he3a0c301, 32'he28cce21, 32'he51c1008, 32'he3510000
  };
  localparam logic [31:0] END_SIG [0:3] = '{
    32'he59f1008, 32'he7910100, 32'he59fe004, 32'he12fff10
  };

  localparam logic [22:0] KNOWN_SIZE [0:NUM_SIZES-1] = '{
    23'h01D5A8, 23'h022B40, 23'h022BCC, 23'h025664, 23'h0257DC,
    23'h025860, 23'h026DF4, 23'h028F84, 23'h02909C, 23'h02914C,
    23'h029164, 23'h029EE8, 23'h02A2EC, 23'h02A318, 23'h02AF18,
    23'h02B184, 23'h02B24C, 23'h02C5B4
  };
  localparam logic [31:0] KNOWN_LOCATION [0:NUM_SIZES-1] = '{
    32'h0239D280, 32'h0238DED8, 32'h0238DF60, 32'h023A5330, 32'h023A54B8,
    32'h023A5538, 32'h023A6AD4, 32'h02391918, 32'h02391A30, 32'h02391ADC,
    32'h02391ADC, 32'h02391F70, 32'h023921BC, 32'h023921D8, 32'h0239227C,
    32'h023924CC, 32'h02392578, 32'h02392E74
  };

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } img_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] location;
  } res_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [22:0] region_bytes;
    logic [1:0]  unit_code;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        start_hit;
    logic        end_hit;
  } qent_t;

  function automatic res_t fallback(logic [22:0] region, logic [1:0] unit);
    res_t r;
    logic found;
    r = '0;
    found = 1'b0;
    if (unit != 2'd0) begin
      for (int j = 0; j < NUM_SIZES; j++) begin
        if (!found && region == KNOWN_SIZE[j]) begin
          found = 1'b1;
          r.status = STATUS_TABLE;
          r.location = KNOWN_LOCATION[j];
        end
      end
    end
    return r;
  endfunction

endpackage

>>> sv/ihsl_regs.sv
// Configuration registers behind the APB-style port.
// Depends on ihsl_pkg.
module ihsl_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ihsl_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output ihsl_pkg::cfg_t                  cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        ihsl_pkg::REG_BASE:   cfg.base_address <= pwdata;
        ihsl_pkg::REG_REGION: cfg.region_bytes <= pwdata[22:0];
        ihsl_pkg::REG_UNIT:   cfg.unit_code <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      ihsl_pkg::REG_BASE:   prdata = cfg.base_address;
      ihsl_pkg::REG_REGION: prdata = 32'(cfg.region_bytes);
      ihsl_pkg::REG_UNIT:   prdata = 32'(cfg.unit_code);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> sv/ihsl_front.sv
// Front end: accepts image words, keeps the recent word window and tags each
// word with start and end signature matches. Depends on ihsl_pkg.
module ihsl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  img_valid,
  output logic                  img_ready,
  input  ihsl_pkg::img_t        img_data,
  input  logic                  q_full,
  output logic                  push,
  output ihsl_pkg::qent_t       push_data
);

  logic [31:0] hist [0:3];
  logic        start_hit;
  logic        end_hit;

  assign img_ready = !q_full;
  assign push = img_valid && img_ready;

  assign start_hit = hist[0] == ihsl_pkg::START_SIG[0] && hist[1] == ihsl_pkg::START_SIG[1] &&
                     hist[2] == ihsl_pkg::START_SIG[2] && hist[3] == ihsl_pkg::START_SIG[3] &&
                     img_data.word == ihsl_pkg::START_SIG[4];
  assign end_hit = hist[1] == ihsl_pkg::END_SIG[0] && hist[2] == ihsl_pkg::END_SIG[1] &&
                   hist[3] == ihsl_pkg::END_SIG[2] && img_data.word == ihsl_pkg::END_SIG[3];

  always_comb begin
    push_data.word = img_data.word;
    push_data.last = img_data.last;
    push_data.start_hit = start_hit;
    push_data.end_hit = end_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 4; j++) hist[j] <= '0;
    end else if (push) begin
      if (img_data.last) begin
        for (int j = 0; j < 4; j++) hist[j] <= '0;
      end else begin
        for (int j = 0; j < 3; j++) hist[j] <= hist[j+1];
        hist[3] <= img_data.word;
      end
    end
  end

endmodule

>>> sv/ihsl_queue.sv
// Short queue of tagged words between the front and back ends.
// Depends on ihsl_pkg. DEPTH must be at least 2.
module ihsl_queue #(
  parameter int DEPTH = ihsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ihsl_pkg::qent_t push_data,
  input  logic            pop,
  output ihsl_pkg::qent_t pop_data,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ihsl_pkg::qent_t   slots [0:DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/ihsl_back.sv
// Back end: stream state machine that walks the tagged words, computes the
// location and holds the result register. Depends on ihsl_pkg.
module ihsl_back #(
  parameter int END_SEARCH_LIMIT = ihsl_pkg::END_SEARCH_LIMIT_DEF,
  parameter int INDEX_WIDTH = ihsl_pkg::INDEX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ihsl_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  ihsl_pkg::qent_t q_data,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_ready,
  output ihsl_pkg::res_t  res_data
);

  localparam int ESC_W = ihsl_pkg::ESC_WIDTH;
  localparam logic [ESC_W-1:0] ESC_LAST = ESC_W'(END_SEARCH_LIMIT - 1);

  typedef enum logic [1:0] {
    PH_START,
    PH_END,
    PH_TABLE,
    PH_RETURN
  } phase_t;

  phase_t                 phase, phase_next;
  logic [INDEX_WIDTH-1:0] idx, idx_next;
  logic [ESC_W-1:0]       esc, esc_next;
  logic [31:0]            tword, tword_next;
  logic                   done, done_next;
  logic                   emit;
  ihsl_pkg::res_t         emit_data;
  ihsl_pkg::res_t         fb;
  logic [31:0]            k32;
  logic [31:0]            rw32;
  logic [31:0]            first_open;
  logic [31:0]            offset;

  assign pop = !q_empty && (!res_valid || res_ready);
  assign fb = ihsl_pkg::fallback(cfg.region_bytes, cfg.unit_code);
  assign k32 = 32'(idx);
  assign rw32 = 32'(cfg.region_bytes[22:2]);
  assign first_open = (k32 >= 32'd3) ? k32 - 32'd3 : '0;
  assign offset = (tword - q_data.word) & 32'hFFFF_FFFC;

  always_comb begin
    phase_next = phase;
    idx_next = idx;
    esc_next = esc;
    tword_next = tword;
    done_next = done;
    emit = 1'b0;
    emit_data = '0;
    if (pop) begin
      if (!done) begin
        unique case (phase)
          PH_START: begin
            if (q_data.start_hit && k32 >= 32'd4 && (k32 - 32'd4) < rw32) begin
              if (END_SEARCH_LIMIT <= 2) begin
                emit = 1'b1;
                emit_data = fb;
                done_next = 1'b1;
              end else begin
                phase_next = PH_END;
                esc_next = ESC_W'(2);
              end
            end else if (rw32 <= first_open) begin
              emit = 1'b1;
              emit_data = fb;
              done_next = 1'b1;
            end
          end
          PH_END: begin
            if (q_data.end_hit) begin
              phase_next = PH_TABLE;
            end else if (esc >= ESC_LAST) begin
              emit = 1'b1;
              emit_data = fb;
              done_next = 1'b1;
            end else begin
              esc_next = esc + 1'b1;
            end
          end
          PH_TABLE: begin
            tword_next = q_data.word;
            phase_next = PH_RETURN;
          end
          PH_RETURN: begin
            emit = 1'b1;
            emit_data.status = ihsl_pkg::STATUS_SCAN;
            emit_data.location = cfg.base_address + ((k32 + 32'd1) << 2) + offset;
            done_next = 1'b1;
          end
        endcase
        if (idx != '1) begin
          idx_next = idx + 1'b1;
        end else if (!done_next) begin
          emit = 1'b1;
          emit_data = fb;
          done_next = 1'b1;
        end
      end
      if (q_data.last) begin
        if (!done_next) begin
          emit = 1'b1;
          emit_data = fb;
        end
        phase_next = PH_START;
        idx_next = '0;
        esc_next = '0;
        tword_next = '0;
        done_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      idx <= '0;
      esc <= '0;
      tword <= '0;
      done <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      idx <= idx_next;
      esc <= esc_next;
      tword <= tword_next;
      done <= done_next;
      if (emit) begin
        res_valid <= 1'b1;
        res_data <= emit_data;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.last) |=> (phase == PH_START && idx == '0 && !done))
    else $error("stream state not cleared after the last word");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    (pop && !done && phase == PH_RETURN) |=>
      (res_valid && res_data.status == ihsl_pkg::STATUS_SCAN))
    else $error("scan result not loaded into the result register");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == ihsl_pkg::STATUS_NONE) |-> res_data.location == '0)
    else $error("nonzero location with not-found status");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !emit)
    else $error("pending result overwritten");
`endif

endmodule

>>> sv/irq_handler_signature_locator_top.sv
// Top level of the interrupt handler signature locator.
// A result is registered in the back end after the word that causes it passes the queue.
// Throughput: one word per cycle, set by the combinational window compare and the
// stream state machine; a stalled result slot stalls the back end, then the queue.
// Reset: synchronous; clears all but queue slots and result data at once; no clearing pass.
// Depends on ihsl_pkg, ihsl_regs, ihsl_front, ihsl_queue and ihsl_back.
module irq_handler_signature_locator_top #(
  parameter int END_SEARCH_LIMIT = ihsl_pkg::END_SEARCH_LIMIT_DEF,
  parameter int INDEX_WIDTH = ihsl_pkg::INDEX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = ihsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             img_valid,
  output logic                             img_ready,
  input  ihsl_pkg::img_t                   img_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output ihsl_pkg::res_t                   res_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ihsl_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ihsl_pkg::cfg_t  cfg;
  ihsl_pkg::qent_t push_data;
  ihsl_pkg::qent_t pop_data;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  ihsl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ihsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .img_valid (img_valid),
    .img_ready (img_ready),
    .img_data  (img_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ihsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ihsl_back #(
    .END_SEARCH_LIMIT (END_SEARCH_LIMIT),
    .INDEX_WIDTH      (INDEX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

>>> dv/irq_handler_signature_locator_top_tb.sv
// Testbench for irq_handler_signature_locator_top: streams code images over the word channel,
// predicts the vector table location of each stream and checks every result transfer.
// Depends on ihsl_pkg and the locator RTL.
module irq_handler_signature_locator_top_tb;

  localparam int IDX_W = 21;
  localparam int END_WINDOWS = 50;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam logic [0:4][31:0] START_WORDS = {
    32'he92d4000, 32'he3a0c301, 32'he28cce21, 32'he51c1008, 32'he3510000
  };
  localparam logic [0:3][31:0] END_WORDS = {
    32'he59f1008, 32'he7910100, 32'he59fe004, 32'he12fff10
  };
  localparam logic [0:17][22:0] IMAGE_SIZES = {
    23'h01D5A8, 23'h022B40, 23'h022BCC, 23'h025664, 23'h0257DC, 23'h025860,
    23'h026DF4, 23'h028F84, 23'h02909C, 23'h02914C, 23'h029164, 23'h029EE8,
    23'h02A2EC, 23'h02A318, 23'h02AF18, 23'h02B184, 23'h02B24C, 23'h02C5B4
  };
  localparam logic [0:17][31:0] TABLE_LOCATIONS = {
    32'h0239D280, 32'h0238DED8, 32'h0238DF60, 32'h023A5330, 32'h023A54B8, 32'h023A5538,
    32'h023A6AD4, 32'h02391918, 32'h02391A30, 32'h02391ADC, 32'h02391ADC, 32'h02391F70,
    32'h023921BC, 32'h023921D8, 32'h0239227C, 32'h023924CC, 32'h02392578, 32'h02392E74
  };

  typedef enum logic [1:0] {SEEK_START, SEEK_END, TAKE_T, TAKE_R} scan_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic img_valid = 1'b0;
  logic img_ready;
  ihsl_pkg::img_t img_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  ihsl_pkg::res_t res_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ihsl_pkg::PADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [31:0] cfg_base = '0;
  logic [22:0] cfg_region = '0;
  logic [1:0] cfg_unit = '0;

  logic [31:0] history [0:4];
  scan_phase_t scan_phase;
  logic [IDX_W-1:0] word_count;
  logic [5:0] window_offset;
  logic [31:0] t_word;
  logic located;

  ihsl_pkg::img_t image_words [$];
  ihsl_pkg::res_t expected_locations [$];
  int unsigned img_gap = 0;
  int unsigned res_stall = 0;
  bit img_bursty = 1'b0;
  bit res_bursty = 1'b0;
  int mismatches = 0;
  int queued_items = 0;
  int streams = 0;
  int quiet_cycles = 0;

  irq_handler_signature_locator_top dut (
    .clk(clk),
    .rst(rst),
    .img_valid(img_valid),
    .img_ready(img_ready),
    .img_data(img_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_scan();
    for (int j = 0; j < 5; j++) history[j] = '0;
    scan_phase = SEEK_START;
    word_count = '0;
    window_offset = '0;
    t_word = '0;
    located = 1'b0;
  endfunction

  function automatic ihsl_pkg::res_t size_table_result();
    ihsl_pkg::res_t r;
    r = '0;
    if (cfg_unit != 2'd0) begin
      for (int j = 17; j >= 0; j--) begin
        if (cfg_region == IMAGE_SIZES[j]) begin
          r.status = ihsl_pkg::STATUS_TABLE;
          r.location = TABLE_LOCATIONS[j];
        end
      end
    end
    return r;
  endfunction

  // One word of the image: advances the scan and queues the result it gives, if any.
  task automatic locate_step(input ihsl_pkg::img_t item);
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] region_words;
    logic [IDX_W-1:0] first_open;
    logic hit;
    logic by_table;
    logic by_scan;
    ihsl_pkg::res_t r;
    k = word_count;
    region_words = cfg_region[22:2];
    by_table = 1'b0;
    by_scan = 1'b0;
    r = '0;
    if (!located) begin
      for (int j = 0; j < 4; j++) history[j] = history[j + 1];
      history[4] = item.word;
      case (scan_phase)
        SEEK_START: begin
          hit = (k >= 4) && ((k - 4) < region_words);
          for (int j = 0; j < 5; j++) if (history[j] != START_WORDS[j]) hit = 1'b0;
          if (hit) begin
            scan_phase = SEEK_END;
            window_offset = 6'd2;
          end else begin
            first_open = (k >= 3) ? IDX_W'(k - 3) : '0;
            if (region_words <= first_open) begin
              by_table = 1'b1;
              located = 1'b1;
            end
          end
        end
        SEEK_END: begin
          hit = 1'b1;
          for (int j = 0; j < 4; j++) if (history[j + 1] != END_WORDS[j]) hit = 1'b0;
          if (hit) begin
            scan_phase = TAKE_T;
          end else if (window_offset >= END_WINDOWS - 1) begin
            by_table = 1'b1;
            located = 1'b1;
          end else begin
            window_offset = window_offset + 6'd1;
          end
        end
        TAKE_T: begin
          t_word = item.word;
          scan_phase = TAKE_R;
        end
        TAKE_R: begin
          r.status = ihsl_pkg::STATUS_SCAN;
          r.location = cfg_base + ((32'(k) + 32'd1) << 2) +
                       ((t_word - item.word) & 32'hFFFFFFFC);
          by_scan = 1'b1;
          located = 1'b1;
        end
      endcase
      if (word_count != '1) begin
        word_count = word_count + 1'b1;
      end else if (!located) begin
        by_table = 1'b1;
        located = 1'b1;
      end
    end
    if (item.last) begin
      if (!located) by_table = 1'b1;
      clear_scan();
    end
    if (by_table) expected_locations.push_back(size_table_result());
    else if (by_scan) expected_locations.push_back(r);
  endtask

  function automatic int unsigned draw_wait(input bit bursty);
    return bursty ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic void report_mismatch(input string what, input ihsl_pkg::res_t want,
                                          input ihsl_pkg::res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected status %0d location %h, got status %0d location %h",
               $time, what, want.status, want.location, got.status, got.location);
  endfunction

  // Word sender: holds each transfer until accepted, then idles for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      img_valid <= 1'b0;
      img_gap <= 0;
    end else begin
      if (img_valid && img_ready) locate_step(img_data);
      if (!img_valid || img_ready) begin
        if (img_gap != 0) begin
          img_gap <= img_gap - 1;
          img_valid <= 1'b0;
        end else if (image_words.size() != 0) begin
          img_data <= image_words.pop_front();
          img_valid <= 1'b1;
          img_gap <= draw_wait(img_bursty);
        end else begin
          img_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_sink
    int unsigned pause;
    ihsl_pkg::res_t want;
    if (rst) begin
      res_ready <= 1'b0;
      res_stall <= 0;
    end else if (res_valid && res_ready) begin
      if (expected_locations.size() == 0) begin
        report_mismatch("unexpected result", '0, res_data);
      end else begin
        want = expected_locations.pop_front();
        if (res_data.status !== want.status || res_data.location !== want.location)
          report_mismatch("wrong result", want, res_data);
      end
      pause = draw_wait(res_bursty);
      res_stall <= pause;
      res_ready <= (pause == 0);
    end else if (res_stall != 0) begin
      res_stall <= res_stall - 1;
      res_ready <= (res_stall == 1);
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (img_valid && img_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ihsl_pkg::REG_BASE: cfg_base = value;
      ihsl_pkg::REG_REGION: cfg_region = value[22:0];
      ihsl_pkg::REG_UNIT: cfg_unit = value[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] base, input logic [22:0] region,
                           input logic [1:0] unit);
    reg_write(ihsl_pkg::REG_BASE, base);
    reg_write(ihsl_pkg::REG_REGION, {9'd0, region});
    reg_write(ihsl_pkg::REG_UNIT, {30'd0, unit});
  endtask

  // Waits until every word is sent and every result is in, then lets the pipeline empty.
  task automatic settle();
    do @(negedge clk);
    while (image_words.size() != 0 || img_valid || expected_locations.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] noise_word();
    case ($urandom_range(0, 9))
      0: return START_WORDS[$urandom_range(0, 4)];
      1: return END_WORDS[$urandom_range(0, 3)];
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_word(input logic [31:0] w, input logic fin);
    ihsl_pkg::img_t it;
    it.word = w;
    it.last = fin;
    image_words.push_back(it);
    queued_items++;
  endfunction

  // Builds lead words, start signature, gap words, end signature, t, r and tail words.
  // A nonzero keep cuts the stream short; a spoil index flips one bit of a signature word.
  task automatic queue_hit_stream(input int lead, input int gap, input logic [31:0] t,
                                  input logic [31:0] r, input int tail, input int keep,
                                  input int spoil);
    logic [31:0] words [$];
    int at;
    repeat (lead) words.push_back(noise_word());
    for (int j = 0; j < 5; j++) words.push_back(START_WORDS[j]);
    repeat (gap) words.push_back(noise_word());
    for (int j = 0; j < 4; j++) words.push_back(END_WORDS[j]);
    words.push_back(t);
    words.push_back(r);
    repeat (tail) words.push_back(noise_word());
    if (spoil >= 0) begin
      at = (spoil < 5) ? lead + spoil : lead + gap + spoil;
      words[at] = words[at] ^ (32'd1 << $urandom_range(0, 31));
    end
    if (keep > 0) while (words.size() > keep) void'(words.pop_back());
    for (int j = 0; j < words.size(); j++) queue_word(words[j], j == words.size() - 1);
    streams++;
  endtask

  function automatic void queue_noise_stream(input int n);
    for (int j = 0; j < n; j++) queue_word(noise_word(), j == n - 1);
    streams++;
  endfunction

  task automatic queue_random_stream();
    int pick;
    int lead;
    int gap;
    pick = $urandom_range(0, 9);
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(43, 46) : $urandom_range(0, 10);
    if (pick <= 5)
      queue_hit_stream(lead, gap, operand(), operand(), $urandom_range(0, 3), 0, -1);
    else if (pick == 6)
      queue_hit_stream(lead, gap, operand(), operand(), 2, $urandom_range(1, lead + gap + 12),
                       -1);
    else if (pick == 7)
      queue_hit_stream(lead, gap, operand(), operand(), 1, 0, $urandom_range(0, 8));
    else if (pick == 8)
      queue_noise_stream($urandom_range(2, 20));
    else
      queue_noise_stream(1);
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return 32'hFFFFFFFF - $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [22:0] pick_region();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 23'($urandom_range(0, 48));
      2: return IMAGE_SIZES[$urandom_range(0, 17)];
      3: return 23'h400000;
      4: return 23'($urandom_range(0, 32'h400000));
      default: return IMAGE_SIZES[$urandom_range(0, 17)] + 23'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    clear_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // With the registers at reset the start search is empty, so the first word gives up.
    @(negedge clk);
    queue_word(32'hFFFFFFFF, 1'b1);
    queue_word(32'h00000000, 1'b0);
    queue_word(32'h00000000, 1'b1);
    settle();

    configure(32'hFFFFFFFF, 23'h400000, 2'd3);
    @(negedge clk);
    queue_hit_stream(0, 0, 32'hFFFFFFFF, 32'h00000000, 0, 0, -1);
    queue_hit_stream(0, 0, 32'h00000000, 32'h00000000, 0, 3, -1);
    settle();

    configure(32'h00000000, IMAGE_SIZES[17], 2'd1);
    @(negedge clk);
    queue_word($urandom, 1'b1);
    settle();

    queued_items = 0;
    streams = 0;
    while (queued_items < 550 || streams < 45) begin
      configure(pick_base(), pick_region(), 2'($urandom_range(0, 3)));
      @(negedge clk);
      img_bursty = ($urandom_range(0, 3) == 0);
      res_bursty = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(5, 9)) queue_random_stream();
      settle();
    end

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
sv/ihsl_pkg.sv
sv/ihsl_regs.sv
sv/ihsl_front.sv
sv/ihsl_queue.sv
sv/ihsl_back.sv
sv/irq_handler_signature_locator_top.sv
dv/irq_handler_signature_locator_top_tb.sv
